FILE: hdl/subtab_pkg.sv
package subtab_pkg;

    // request codes
    typedef enum logic [1:0] {
        CMD_SUBSCRIBE   = 2'd0,
        CMD_UNSUBSCRIBE = 2'd1,
        CMD_QUERY       = 2'd2,
        CMD_LIST        = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAIR_FIN,
        ST_LIST_FIN
    } state_t;

    // width of the listed subscriber port and of the count field
    localparam int OUT_WIDTH   = 32;
    localparam int COUNT_WIDTH = 7;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic pair_fin;
        logic list_fin;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_list;
        logic found;
        logic list_full;
        logic scan_done;
    } stat_t;

endpackage

FILE: hdl/subtab_ctrl.sv
module subtab_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  subtab_pkg::stat_t  stat,
    output subtab_pkg::ctrl_t  ctrl,
    output logic               busy
);

    subtab_pkg::state_t state_reg;
    subtab_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= subtab_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            subtab_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = subtab_pkg::ST_SCAN;
                end
            end
            subtab_pkg::ST_SCAN:
            begin
                if (stat.is_list)
                begin
                    if (stat.list_full || stat.scan_done)
                    begin
                        state_next = subtab_pkg::ST_LIST_FIN;
                    end
                end
                else if (stat.found || stat.scan_done)
                begin
                    state_next = subtab_pkg::ST_PAIR_FIN;
                end
            end
            subtab_pkg::ST_PAIR_FIN:
            begin
                state_next = subtab_pkg::ST_IDLE;
            end
            subtab_pkg::ST_LIST_FIN:
            begin
                state_next = subtab_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = subtab_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            subtab_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            subtab_pkg::ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            subtab_pkg::ST_PAIR_FIN:
            begin
                ctrl.pair_fin = 1'b1;
            end
            subtab_pkg::ST_LIST_FIN:
            begin
                ctrl.list_fin = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/subtab_dp.sv
module subtab_dp #(
    parameter int MAX_ENTRIES = 256,
    parameter int ID_WIDTH    = 32,
    parameter int LIST_LIMIT  = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  subtab_pkg::ctrl_t                   ctrl,
    output subtab_pkg::stat_t                   stat,
    input  logic [1:0]                          command,
    input  logic [ID_WIDTH-1:0]                 subscriber_id,
    input  logic [ID_WIDTH-1:0]                 target_id,
    input  logic [subtab_pkg::COUNT_WIDTH-1:0]  max_count,
    output logic                                result_valid,
    output logic                                status,
    output logic                                subscribed,
    output logic [subtab_pkg::OUT_WIDTH-1:0]    subscriber_out,
    output logic                                has_entry,
    output logic                                last
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int USE_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = subtab_pkg::COUNT_WIDTH;

    // entry store: subscriber, target and active mark share one address
    logic [ID_WIDTH-1:0] mem_sub [MAX_ENTRIES];
    logic [ID_WIDTH-1:0] mem_tgt [MAX_ENTRIES];
    logic                mem_act [MAX_ENTRIES];

    // latched request
    subtab_pkg::cmd_t    cmd_reg;
    logic [ID_WIDTH-1:0] sub_reg;
    logic [ID_WIDTH-1:0] tgt_reg;
    logic [CW-1:0]       limit_reg;

    logic [USE_W-1:0]    used_reg;
    logic [USE_W-1:0]    used_next;

    // scan pointer and reads still to issue
    logic [IDX_W-1:0]    ptr_reg;
    logic [USE_W-1:0]    cnt_reg;

    // registered read data
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ID_WIDTH-1:0] rd_sub_reg;
    logic [ID_WIDTH-1:0] rd_tgt_reg;
    logic                rd_act_reg;

    // pair search result
    logic                found_reg;
    logic [IDX_W-1:0]    found_idx_reg;
    logic                found_act_reg;

    // list: one held subscriber, emitted once it is known whether it is the final one
    logic                pend_valid_reg;
    logic [ID_WIDTH-1:0] pend_sub_reg;
    logic [CW-1:0]       nfound_reg;

    // result registers
    logic                     valid_reg, valid_next;
    logic                     status_reg, status_next;
    logic                     subscr_reg, subscr_next;
    logic [ID_WIDTH-1:0]      who_reg, who_next;
    logic                     has_reg, has_next;
    logic                     last_reg, last_next;

    logic                is_list;
    logic                list_full;
    logic                rd_en;
    logic                hit_pair;
    logic                hit_list;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic                wr_act;
    logic [CW-1:0]       limit_in;

    assign is_list   = (cmd_reg == subtab_pkg::CMD_LIST);
    assign list_full = (nfound_reg == limit_reg);
    assign rd_en     = ctrl.scan && (cnt_reg != '0);

    // count saturated to the list limit
    assign limit_in = (max_count > CW'(LIST_LIMIT)) ? CW'(LIST_LIMIT) : max_count;

    // matches on the data read last cycle
    assign hit_pair = ctrl.scan && !is_list && rd_valid_reg && !found_reg
                      && (rd_sub_reg == sub_reg) && (rd_tgt_reg == tgt_reg);
    assign hit_list = ctrl.scan && is_list && rd_valid_reg && !list_full
                      && rd_act_reg && (rd_tgt_reg == tgt_reg);

    assign stat.is_list   = is_list;
    assign stat.found     = found_reg;
    assign stat.list_full = list_full;
    assign stat.scan_done = (cnt_reg == '0) && !rd_valid_reg;

    // store update and results at the end of a request, and list results on a further match
    always_comb
    begin
        wr_en       = 1'b0;
        wr_idx      = found_idx_reg;
        wr_act      = 1'b1;
        used_next   = used_reg;
        valid_next  = 1'b0;
        status_next = 1'b0;
        subscr_next = 1'b0;
        who_next    = '0;
        has_next    = 1'b0;
        last_next   = 1'b0;
        if (ctrl.pair_fin)
        begin
            valid_next = 1'b1;
            last_next  = 1'b1;
            case (cmd_reg)
                subtab_pkg::CMD_SUBSCRIBE:
                begin
                    if (found_reg)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (used_reg < USE_W'(MAX_ENTRIES))
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = IDX_W'(used_reg);
                        used_next = used_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                subtab_pkg::CMD_UNSUBSCRIBE:
                begin
                    if (found_reg && found_act_reg)
                    begin
                        wr_en  = 1'b1;
                        wr_act = 1'b0;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                default:
                begin
                    subscr_next = found_reg && found_act_reg;
                end
            endcase
        end
        else if (ctrl.list_fin)
        begin
            // held subscriber is the final one, or the list is empty
            valid_next = 1'b1;
            last_next  = 1'b1;
            has_next   = pend_valid_reg;
            who_next   = pend_valid_reg ? pend_sub_reg : '0;
        end
        else if (hit_list && pend_valid_reg)
        begin
            // a further match shows the held one is not final
            valid_next = 1'b1;
            has_next   = 1'b1;
            who_next   = pend_sub_reg;
        end
    end

    // entry store access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_sub[wr_idx] <= sub_reg;
            mem_tgt[wr_idx] <= tgt_reg;
            mem_act[wr_idx] <= wr_act;
        end
        if (rd_en)
        begin
            rd_sub_reg <= mem_sub[ptr_reg];
            rd_tgt_reg <= mem_tgt[ptr_reg];
            rd_act_reg <= mem_act[ptr_reg];
        end
    end

    // latched request, scan payload and result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= subtab_pkg::cmd_t'(command);
            sub_reg   <= subscriber_id;
            tgt_reg   <= target_id;
            limit_reg <= limit_in;
        end
        if (rd_en)
        begin
            rd_idx_reg <= ptr_reg;
        end
        if (hit_pair)
        begin
            found_idx_reg <= rd_idx_reg;
            found_act_reg <= rd_act_reg;
        end
        if (hit_list)
        begin
            pend_sub_reg <= rd_sub_reg;
        end
        status_reg <= status_next;
        subscr_reg <= subscr_next;
        who_reg    <= who_next;
        has_reg    <= has_next;
        last_reg   <= last_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            nfound_reg     <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_en;
            if (ctrl.load)
            begin
                // list walks down from the newest entry, pair search walks up
                ptr_reg        <= (command == subtab_pkg::CMD_LIST) ? IDX_W'(used_reg - 1'b1)
                                                                    : '0;
                cnt_reg        <= used_reg;
                found_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
                nfound_reg     <= '0;
            end
            else if (rd_en)
            begin
                ptr_reg <= is_list ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (hit_pair)
            begin
                found_reg <= 1'b1;
            end
            if (hit_list)
            begin
                pend_valid_reg <= 1'b1;
                nfound_reg     <= nfound_reg + 1'b1;
            end
        end
    end

    assign result_valid   = valid_reg;
    assign status         = status_reg;
    assign subscribed     = subscr_reg;
    assign subscriber_out = subtab_pkg::OUT_WIDTH'(who_reg);
    assign has_entry      = has_reg;
    assign last           = last_reg;

endmodule

FILE: hdl/subscription_table.sv
// Subscription table. A request is taken when start is high and busy is low.
// busy stays high while the request is worked on and falls in the cycle in
// which its final result is presented, so the next request can be taken at
// the end of that cycle. Results appear for one cycle each, marked by
// result_valid, and cannot be held off, so the receiver must take every one as
// it comes; last marks the final result of a request. Each request walks the
// stored entries through the single read port of the entry store, one entry
// per cycle; list stops early once max_count subscribers, saturated to
// LIST_LIMIT, have been found, and a pair search stops at its first match.
// List results come newest entry first; the last listed subscriber is held
// until the scan ends and is issued from ST_LIST_FIN through the result
// registers. No clearing pass is needed after reset: only entries below the
// fill count are ever read.
module subscription_table #(
    parameter int MAX_ENTRIES = 256,
    parameter int ID_WIDTH    = 32,
    parameter int LIST_LIMIT  = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          command,
    input  logic [ID_WIDTH-1:0]                 subscriber_id,
    input  logic [ID_WIDTH-1:0]                 target_id,
    input  logic [subtab_pkg::COUNT_WIDTH-1:0]  max_count,
    output logic                                result_valid,
    output logic                                status,
    output logic                                subscribed,
    output logic [subtab_pkg::OUT_WIDTH-1:0]    subscriber_out,
    output logic                                has_entry,
    output logic                                last
);

    subtab_pkg::ctrl_t ctrl;
    subtab_pkg::stat_t stat;

    // sequencer
    subtab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // entry store and scan datapath
    subtab_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_WIDTH    (ID_WIDTH),
        .LIST_LIMIT  (LIST_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .command        (command),
        .subscriber_id  (subscriber_id),
        .target_id      (target_id),
        .max_count      (max_count),
        .result_valid   (result_valid),
        .status         (status),
        .subscribed     (subscribed),
        .subscriber_out (subscriber_out),
        .has_entry      (has_entry),
        .last           (last)
    );

endmodule

FILE: hdl/subtab_checker.sv
module subtab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        status,
    input logic [31:0] subscriber_out,
    input logic        has_entry,
    input logic        last
);

    // a taken request keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after request taken");

    // a result without a listed subscriber ends its request
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_entry |-> last)
        else $error("result without subscriber not marked last");

    // no subscriber value on results that carry none
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_entry |-> subscriber_out == 32'd0)
        else $error("subscriber_out not zero without entry");

    // failures never list a subscriber
    a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> !has_entry)
        else $error("failure result carries a subscriber");

    // a final result is never followed directly by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result directly after final result");

endmodule

bind subscription_table subtab_checker u_subtab_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_valid   (result_valid),
    .status         (status),
    .subscriber_out (subscriber_out),
    .has_entry      (has_entry),
    .last           (last)
);

FILE: dv/subtab_checker.sv
module subtab_scoreboard #(
    parameter int MAX_ENTRIES = 256,
    parameter int ID_WIDTH    = 32,
    parameter int LIST_LIMIT  = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         command,
    input  logic [ID_WIDTH-1:0]                subscriber_id,
    input  logic [ID_WIDTH-1:0]                target_id,
    input  logic [subtab_pkg::COUNT_WIDTH-1:0] max_count,
    input  logic                               result_valid,
    input  logic                               status,
    input  logic                               subscribed,
    input  logic [subtab_pkg::OUT_WIDTH-1:0]   subscriber_out,
    input  logic                               has_entry,
    input  logic                               last,
    output int                                 errors,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                             status;
        logic                             subscribed;
        logic [subtab_pkg::OUT_WIDTH-1:0] who;
        logic                             has_entry;
        logic                             last;
    } reply_t;

    // shadow copy of the subscription table
    logic [ID_WIDTH-1:0] pair_sub [MAX_ENTRIES];
    logic [ID_WIDTH-1:0] pair_tgt [MAX_ENTRIES];
    bit                  pair_on  [MAX_ENTRIES];
    int                  pairs_used = 0;

    reply_t              replies_due [$];
    int                  mismatch_count = 0;
    reply_t              got;
    reply_t              want;

    // single-result reply for the pair requests and the empty list
    function automatic reply_t plain_reply(input logic st, input logic sb);
        reply_t r;
        r            = '0;
        r.status     = st;
        r.subscribed = sb;
        r.last       = 1'b1;
        return r;
    endfunction

    // index of the first stored pair that matches, -1 when absent
    function automatic int find_pair(input logic [ID_WIDTH-1:0] sub,
                                     input logic [ID_WIDTH-1:0] tgt);
        int i;
        for (i = 0; i < pairs_used; i++)
        begin
            if (pair_sub[i] == sub && pair_tgt[i] == tgt)
                return i;
        end
        return -1;
    endfunction

    // update the shadow table and queue the results a request should give
    task automatic apply_request(input subtab_pkg::cmd_t cmd,
                                 input logic [ID_WIDTH-1:0] sub,
                                 input logic [ID_WIDTH-1:0] tgt,
                                 input logic [subtab_pkg::COUNT_WIDTH-1:0] cnt);
        int     hit;
        int     limit;
        int     found;
        int     i;
        reply_t held;
        hit  = find_pair(sub, tgt);
        held = '0;
        case (cmd)
            subtab_pkg::CMD_SUBSCRIBE:
            begin
                if (hit >= 0)
                begin
                    pair_on[hit] = 1'b1;
                    replies_due.push_back(plain_reply(1'b0, 1'b0));
                end
                else if (pairs_used >= MAX_ENTRIES)
                begin
                    replies_due.push_back(plain_reply(1'b1, 1'b0));
                end
                else
                begin
                    pair_sub[pairs_used] = sub;
                    pair_tgt[pairs_used] = tgt;
                    pair_on[pairs_used]  = 1'b1;
                    pairs_used++;
                    replies_due.push_back(plain_reply(1'b0, 1'b0));
                end
            end
            subtab_pkg::CMD_UNSUBSCRIBE:
            begin
                if (hit < 0 || !pair_on[hit])
                begin
                    replies_due.push_back(plain_reply(1'b1, 1'b0));
                end
                else
                begin
                    pair_on[hit] = 1'b0;
                    replies_due.push_back(plain_reply(1'b0, 1'b0));
                end
            end
            subtab_pkg::CMD_QUERY:
            begin
                replies_due.push_back(plain_reply(1'b0, hit >= 0 && pair_on[hit]));
            end
            default:
            begin
                // newest entry first, count saturated at the list limit
                limit = (cnt > LIST_LIMIT) ? LIST_LIMIT : int'(cnt);
                found = 0;
                i     = pairs_used;
                while (i > 0 && found < limit)
                begin
                    i--;
                    if (pair_on[i] && pair_tgt[i] == tgt)
                    begin
                        if (found > 0)
                            replies_due.push_back(held);
                        held           = '0;
                        held.who       = subtab_pkg::OUT_WIDTH'(pair_sub[i]);
                        held.has_entry = 1'b1;
                        found++;
                    end
                end
                if (found == 0)
                begin
                    replies_due.push_back(plain_reply(1'b0, 1'b0));
                end
                else
                begin
                    held.last = 1'b1;
                    replies_due.push_back(held);
                end
            end
        endcase
    endtask

    // compare results, then predict for a request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                got.status     = status;
                got.subscribed = subscribed;
                got.who        = subscriber_out;
                got.has_entry  = has_entry;
                got.last       = last;
                if (replies_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected result: status %0b subscribed %0b",
                                  " subscriber %h has_entry %0b last %0b"},
                                 got.status, got.subscribed, got.who, got.has_entry,
                                 got.last);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.subscribed !== want.subscribed ||
                        got.who !== want.who || got.has_entry !== want.has_entry ||
                        got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display({"mismatch: expected status %0b subscribed %0b",
                                      " subscriber %h has_entry %0b last %0b"},
                                     want.status, want.subscribed, want.who,
                                     want.has_entry, want.last);
                            $display({"          actual   status %0b subscribed %0b",
                                      " subscriber %h has_entry %0b last %0b"},
                                     got.status, got.subscribed, got.who,
                                     got.has_entry, got.last);
                        end
                    end
                end
            end
            if (start && !busy)
                apply_request(subtab_pkg::cmd_t'(command), subscriber_id, target_id,
                              max_count);
        end
        errors  <= mismatch_count;
        pending <= replies_due.size();
    end

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 256;
    localparam int ID_WIDTH    = 32;
    localparam int LIST_LIMIT  = 64;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [1:0]                           command;
    logic [ID_WIDTH-1:0]                  subscriber_id;
    logic [ID_WIDTH-1:0]                  target_id;
    logic [subtab_pkg::COUNT_WIDTH-1:0]   max_count;
    logic                                 result_valid;
    logic                                 status;
    logic                                 subscribed;
    logic [subtab_pkg::OUT_WIDTH-1:0]     subscriber_out;
    logic                                 has_entry;
    logic                                 last;
    int                                   errors;
    int                                   pending;

    // stimulus bookkeeping
    bit                  no_idle = 1'b0;
    bit                  known_pairs [bit [63:0]];
    logic [ID_WIDTH-1:0] sub_pool [10];
    logic [ID_WIDTH-1:0] tgt_pool [4];
    logic [ID_WIDTH-1:0] hot_target;
    logic [ID_WIDTH-1:0] hot_subs [$];

    subscription_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_WIDTH    (ID_WIDTH),
        .LIST_LIMIT  (LIST_LIMIT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .subscriber_id  (subscriber_id),
        .target_id      (target_id),
        .max_count      (max_count),
        .result_valid   (result_valid),
        .status         (status),
        .subscribed     (subscribed),
        .subscriber_out (subscriber_out),
        .has_entry      (has_entry),
        .last           (last)
    );

    subtab_scoreboard #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_WIDTH    (ID_WIDTH),
        .LIST_LIMIT  (LIST_LIMIT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .subscriber_id  (subscriber_id),
        .target_id      (target_id),
        .max_count      (max_count),
        .result_valid   (result_valid),
        .status         (status),
        .subscribed     (subscribed),
        .subscriber_out (subscriber_out),
        .has_entry      (has_entry),
        .last           (last),
        .errors         (errors),
        .pending        (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // issue one request and wait until it is taken
    task automatic send_request(input subtab_pkg::cmd_t cmd,
                                input logic [ID_WIDTH-1:0] sub,
                                input logic [ID_WIDTH-1:0] tgt,
                                input logic [6:0] cnt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        // idle gap, sometimes counted from the end of the previous request
        if (gap > 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        subscriber_id <= sub;
        target_id     <= tgt;
        max_count     <= cnt;
        if (cmd == subtab_pkg::CMD_SUBSCRIBE)
            known_pairs[{sub, tgt}] = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending until every outstanding result has come back
    task automatic hold_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [ID_WIDTH-1:0] pick_subscriber();
        if ($urandom_range(0, 99) < 85)
            return sub_pool[$urandom_range(0, 9)];
        return $urandom;
    endfunction

    function automatic logic [ID_WIDTH-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return tgt_pool[$urandom_range(0, 3)];
        if (r < 90)
            return hot_target;
        return $urandom;
    endfunction

    // any count value
    function automatic logic [6:0] any_count();
        return 7'($urandom_range(0, 127));
    endfunction

    // list counts: mostly small, some around and above the limit
    function automatic logic [6:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd63;
            2: return 7'd64;
            3: return 7'd65;
            4: return 7'd127;
            5: return any_count();
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // mixed request over the small id pools, with some noise ids
    task automatic send_random_request();
        int                  r;
        logic [ID_WIDTH-1:0] sub;
        logic [ID_WIDTH-1:0] tgt;
        r   = $urandom_range(0, 99);
        sub = pick_subscriber();
        tgt = pick_target();
        if (r < 35)
            send_request(subtab_pkg::CMD_SUBSCRIBE, sub, tgt, any_count());
        else if (r < 55)
            send_request(subtab_pkg::CMD_UNSUBSCRIBE, sub, tgt, any_count());
        else if (r < 75)
            send_request(subtab_pkg::CMD_QUERY, sub, tgt, any_count());
        else
            send_request(subtab_pkg::CMD_LIST, $urandom, tgt, pick_count());
    endtask

    // random pacing: bursts without idling and the odd drain
    task automatic vary_pacing();
        if ($urandom_range(0, 24) == 0)
            no_idle = !no_idle;
        if ($urandom_range(0, 49) == 0)
            hold_for_results();
    endtask

    // stimulus
    initial
    begin
        int                  k;
        int                  r;
        logic [ID_WIDTH-1:0] sub;
        start         = 1'b0;
        command       = subtab_pkg::CMD_SUBSCRIBE;
        subscriber_id = '0;
        target_id     = '0;
        max_count     = '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sub_pool[0] = '0;
        sub_pool[1] = '1;
        for (k = 2; k < 10; k++)
            sub_pool[k] = $urandom;
        tgt_pool[0] = '0;
        tgt_pool[1] = '1;
        tgt_pool[2] = $urandom;
        tgt_pool[3] = $urandom;
        hot_target  = $urandom;

        // directed: empty table, absent and inactive pairs, reactivation, list order
        send_request(subtab_pkg::CMD_LIST, '1, '0, 7'd5);
        send_request(subtab_pkg::CMD_QUERY, '0, '0, 7'd0);
        send_request(subtab_pkg::CMD_UNSUBSCRIBE, '0, '0, 7'd127);
        send_request(subtab_pkg::CMD_SUBSCRIBE, '0, '0, 7'd0);
        send_request(subtab_pkg::CMD_SUBSCRIBE, '0, '0, 7'd127);
        send_request(subtab_pkg::CMD_QUERY, '0, '0, 7'd64);
        send_request(subtab_pkg::CMD_SUBSCRIBE, '1, '1, 7'd1);
        send_request(subtab_pkg::CMD_SUBSCRIBE, '1, '0, 7'd2);
        send_request(subtab_pkg::CMD_SUBSCRIBE, 32'h1234_5678, '0, 7'd3);
        send_request(subtab_pkg::CMD_LIST, '0, '0, 7'd127);
        send_request(subtab_pkg::CMD_LIST, '0, '0, 7'd0);
        send_request(subtab_pkg::CMD_LIST, '1, '0, 7'd1);
        no_idle = 1'b1;
        send_request(subtab_pkg::CMD_UNSUBSCRIBE, '1, '0, 7'd0);
        send_request(subtab_pkg::CMD_UNSUBSCRIBE, '1, '0, 7'd0);
        send_request(subtab_pkg::CMD_QUERY, '1, '0, 7'd0);
        send_request(subtab_pkg::CMD_QUERY, '0, '1, 7'd0);
        send_request(subtab_pkg::CMD_LIST, '0, '0, 7'd64);
        no_idle = 1'b0;
        send_request(subtab_pkg::CMD_SUBSCRIBE, '1, '0, 7'd0);
        send_request(subtab_pkg::CMD_LIST, $urandom, '0, 7'd2);
        send_request(subtab_pkg::CMD_LIST, '0, '1, 7'd100);
        send_request(subtab_pkg::CMD_LIST, $urandom, 32'h5555_5555, 7'd8);
        hold_for_results();

        // random requests over small pools while the table is partly filled
        for (k = 0; k < 30; k++)
        begin
            vary_pacing();
            send_random_request();
        end
        hold_for_results();

        // fill the table, mostly new subscribers of one busy target
        while (known_pairs.num() < MAX_ENTRIES)
        begin
            vary_pacing();
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                sub = $urandom;
                hot_subs.push_back(sub);
                send_request(subtab_pkg::CMD_SUBSCRIBE, sub, hot_target, any_count());
            end
            else if (r < 92 && hot_subs.size() > 0)
            begin
                send_request(subtab_pkg::CMD_LIST, $urandom, hot_target, pick_count());
            end
            else
            begin
                send_random_request();
            end
        end
        hold_for_results();

        // full table: failing appends, reactivation and long lists
        send_request(subtab_pkg::CMD_LIST, $urandom, hot_target, 7'd127);
        send_request(subtab_pkg::CMD_SUBSCRIBE, $urandom, $urandom, 7'd0);
        for (k = 0; k < 20; k++)
        begin
            vary_pacing();
            r   = $urandom_range(0, 99);
            sub = hot_subs[$urandom_range(0, hot_subs.size() - 1)];
            if (r < 20)
                send_request(subtab_pkg::CMD_SUBSCRIBE, $urandom, pick_target(),
                             any_count());
            else if (r < 35)
                send_request(subtab_pkg::CMD_SUBSCRIBE, sub, hot_target, any_count());
            else if (r < 55)
                send_request(subtab_pkg::CMD_UNSUBSCRIBE, sub, hot_target, any_count());
            else if (r < 65)
                send_request(subtab_pkg::CMD_QUERY, sub, hot_target, any_count());
            else if (r < 90)
                send_request(subtab_pkg::CMD_LIST, $urandom, hot_target, pick_count());
            else
                send_random_request();
        end

        // drain, then allow one more scan for stray results
        hold_for_results();
        repeat (MAX_ENTRIES + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/subtab_pkg.sv
hdl/subtab_ctrl.sv
hdl/subtab_dp.sv
hdl/subscription_table.sv
hdl/subtab_checker.sv
dv/subtab_checker.sv
dv/tb.sv
